FILE: rtl/matrix_inverse_3x3_cofactor_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX_INVERSE_3X3_COFACTOR_ASSERT_SVH
`define MATRIX_INVERSE_3X3_COFACTOR_ASSERT_SVH

// Check a property while out of reset.
`define MINV3_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MINV3_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/minv3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse block.
package minv3_pkg;

   localparam int DIM   = 3;
   localparam int LANES = DIM * DIM;

   localparam int STATUS_W = 2;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_SINGULAR  = 2'd1;
   localparam status_type STATUS_SATURATED = 2'd2;

endpackage

FILE: rtl/minv3_cofactor.sv
// Adjugate and determinant of a 3x3 matrix in four pipeline stages.
module minv3_cofactor import minv3_pkg::*; #(
   parameter int IW = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [IW-1:0]  elem_i [LANES],
   output logic signed [2*IW:0]  adj_o  [LANES],
   output logic signed [3*IW+2:0] det_o
);

   localparam int MW = 2 * IW;
   localparam int PW = 2 * IW + 1;
   localparam int TW = IW + PW;
   localparam int DW = 3 * IW + 3;

   logic signed [MW-1:0] prod_a_ff [DIM][DIM];
   logic signed [MW-1:0] prod_b_ff [DIM][DIM];
   logic signed [PW-1:0] adj2_ff   [DIM][DIM];
   logic signed [PW-1:0] adj3_ff   [DIM][DIM];
   logic signed [PW-1:0] adj4_ff   [DIM][DIM];
   logic signed [IW-1:0] col1a_ff  [DIM];
   logic signed [IW-1:0] col1b_ff  [DIM];
   logic signed [TW-1:0] dp_ff     [DIM];
   logic signed [DW-1:0] det_ff;

   // Element a[row][col] sits at elem_i[col*3+row]
   for (genvar r = 0; r < DIM; r++) begin : g_row
      localparam int P = (r + 1) % DIM;
      localparam int Q = (r + 2) % DIM;
      for (genvar j = 0; j < DIM; j++) begin : g_col
         localparam int J1 = (j + 1) % DIM;
         localparam int J2 = (j + 2) % DIM;

         // Cross product terms, then their difference
         always_ff @(posedge clock) begin
            if (en) begin
               prod_a_ff[r][j] <= elem_i[P*DIM+J1] * elem_i[Q*DIM+J2];
               prod_b_ff[r][j] <= elem_i[P*DIM+J2] * elem_i[Q*DIM+J1];
               adj2_ff[r][j]   <= PW'(prod_a_ff[r][j]) - PW'(prod_b_ff[r][j]);
               adj3_ff[r][j]   <= adj2_ff[r][j];
               adj4_ff[r][j]   <= adj3_ff[r][j];
            end
         end

         // Transposed order: lane c*3+r carries adj[r][c]
         assign adj_o[j*DIM+r] = adj4_ff[r][j];
      end
   end

   // Determinant as column 1 dotted with the first adjugate row
   for (genvar j = 0; j < DIM; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            col1a_ff[j] <= elem_i[j];
            col1b_ff[j] <= col1a_ff[j];
            dp_ff[j]    <= col1b_ff[j] * adj2_ff[0][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
      end
   end

   assign det_o = det_ff;

endmodule

FILE: rtl/minv3_div_lane.sv
// One divider lane: cofactor scaled by a power of two over the determinant, saturated.
module minv3_div_lane #(
   parameter int PW = 33,
   parameter int DW = 51,
   parameter int SH = 28,
   parameter int OW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [PW-1:0] num_i,
   input  logic signed [DW-1:0] den_i,
   output logic [OW-1:0]        quo_o,
   output logic                 sat_o
);

   localparam int NXW = PW + SH + OW;
   localparam int RW  = PW + SH;
   localparam int XW  = NXW + DW;

   logic          neg_a_ff;
   logic [PW-1:0] num_abs_ff;
   logic [DW-1:0] den_abs_ff;

   logic [DW-1:0] rem_ff [OW+1];
   logic [OW-1:0] low_ff [OW+1];
   logic [OW-1:0] quo_ff [OW+1];
   logic [DW-1:0] dv_ff  [OW+1];
   logic          neg_ff [OW+1];
   logic          ovf_ff [OW+1];

   logic [NXW-1:0] nx;
   logic [RW-1:0]  r0;
   logic [XW-1:0]  r0x;
   logic           over0;

   logic [OW-1:0] lim;
   logic          over;
   logic [OW-1:0] mag;
   logic [OW-1:0] quo_out_ff;
   logic          sat_ff;

   // Take magnitudes and the result sign
   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff   <= num_i[PW-1] != den_i[DW-1];
         num_abs_ff <= num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
         den_abs_ff <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      end
   end

   // Split the scaled dividend; a high part not below the divisor overflows
   always_comb begin
      nx    = NXW'(num_abs_ff) << SH;
      r0    = nx[NXW-1:OW];
      r0x   = XW'(r0);
      over0 = r0x >= XW'(den_abs_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0x[DW-1:0];
         low_ff[0] <= nx[OW-1:0];
         quo_ff[0] <= '0;
         dv_ff[0]  <= den_abs_ff;
         neg_ff[0] <= neg_a_ff;
         ovf_ff[0] <= over0;
      end
   end

   // One restoring quotient bit per stage
   for (genvar s = 0; s < OW; s++) begin : g_stage
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      always_comb begin
         trial = {rem_ff[s], low_ff[s][OW-1]};
         diff  = trial - {1'b0, dv_ff[s]};
         ge    = trial >= {1'b0, dv_ff[s]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[s+1] <= {low_ff[s][OW-2:0], 1'b0};
            quo_ff[s+1] <= {quo_ff[s][OW-2:0], ge};
            dv_ff[s+1]  <= dv_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // Clamp to the signed output range and apply the sign
   always_comb begin
      lim  = neg_ff[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      over = ovf_ff[OW] || (quo_ff[OW] > lim);
      mag  = over ? lim : quo_ff[OW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_out_ff <= neg_ff[OW] ? OW'(-mag) : mag;
         sat_ff     <= over;
      end
   end

   assign quo_o = quo_out_ff;
   assign sat_o = sat_ff;

endmodule

FILE: rtl/matrix_inverse_3x3_cofactor.sv
// Throughput: one matrix per cycle; nine divider lanes run side by side, one quotient bit
// per stage, so the restoring divider depth sets the latency.
// Back-pressure on the result side stalls the whole pipeline; bubbles do not cost cycles.
// Reset (synchronous, active high) clears only the valid pipeline; data registers keep junk.
module matrix_inverse_3x3_cofactor import minv3_pkg::*; #(
   parameter int IN_WIDTH  = 16,
   parameter int IN_FRAC   = 12,
   parameter int OUT_WIDTH = 32,
   parameter int OUT_FRAC  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // m11, m21, m31, m12, m22, m32, m13, m23, m33 from bit 0 up, zero padded
   input  logic [((LANES*IN_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inv11, inv21, inv31, inv12, inv22, inv32, inv13, inv23, inv33, status from bit 0 up
   output logic [((LANES*OUT_WIDTH+STATUS_W+7)/8)*8-1:0] rsp_tdata
);

`include "matrix_inverse_3x3_cofactor_assert.svh"

   localparam int PW  = 2 * IN_WIDTH + 1;
   localparam int DW  = 3 * IN_WIDTH + 3;
   localparam int SH  = IN_FRAC + OUT_FRAC;
   localparam int ZL  = OUT_WIDTH + 3;
   localparam int LAT = OUT_WIDTH + 8;
   localparam int OTW = ((LANES*OUT_WIDTH+STATUS_W+7)/8)*8;

   logic                        en;
   logic [LAT-1:0]              v_ff;
   logic signed [IN_WIDTH-1:0]  elem [LANES];
   logic signed [PW-1:0]        adj  [LANES];
   logic signed [DW-1:0]        det;
   logic [OUT_WIDTH-1:0]        quo  [LANES];
   logic [LANES-1:0]            sat;
   logic [ZL-1:0]               zero_ff;
   logic [OTW-1:0]              rsp_tdata_ff;
   logic [OTW-1:0]              rsp_tdata_in;

   // Advance whenever the result register is empty or being drained
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_tvalid};
      end
   end

   // Unpack the matrix elements
   for (genvar k = 0; k < LANES; k++) begin : g_unpack
      assign elem[k] = req_tdata[k*IN_WIDTH +: IN_WIDTH];
   end

   minv3_cofactor #(.IW(IN_WIDTH)) u_cofactor (
      .clock  (clock),
      .en     (en),
      .elem_i (elem),
      .adj_o  (adj),
      .det_o  (det)
   );

   // One divider lane per inverse element
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      minv3_div_lane #(
         .PW (PW),
         .DW (DW),
         .SH (SH),
         .OW (OUT_WIDTH)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .num_i (adj[k]),
         .den_i (det),
         .quo_o (quo[k]),
         .sat_o (sat[k])
      );
   end

   // Carry the singular flag alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[ZL-2:0], det == '0};
      end
   end

   // Merge the lanes into one result
   always_comb begin
      rsp_tdata_in = '0;
      if (zero_ff[ZL-1]) begin
         rsp_tdata_in[LANES*OUT_WIDTH +: STATUS_W] = STATUS_SINGULAR;
      end else begin
         for (int k = 0; k < LANES; k++) begin
            rsp_tdata_in[k*OUT_WIDTH +: OUT_WIDTH] = quo[k];
         end
         rsp_tdata_in[LANES*OUT_WIDTH +: STATUS_W] = (|sat) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

   `MINV3_CHECK_ALWAYS(a_reset_empties, reset |=> !rsp_tvalid, "result valid right after reset")
   `MINV3_CHECK(a_singular_zero, (rsp_tvalid && rsp_tdata[LANES*OUT_WIDTH +: STATUS_W] == STATUS_SINGULAR) |-> (rsp_tdata[LANES*OUT_WIDTH-1:0] == '0), "singular result not all zero")
   `MINV3_CHECK(a_stall_holds, !en |=> $stable(v_ff), "valid pipeline moved while stalled")

endmodule
